/* hw/rtl/bdq_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and pointer helpers for the bounded deque.
// No dependencies; imported by the interfaces, the top level and the checker.
package bdq_pkg;

  localparam int DEPTH   = 16;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 2'd0,
    K_POP_FRONT  = 2'd1,
    K_PUSH_BACK  = 2'd2,
    K_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

/* hw/rtl/bdq_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for deque operations and results.
// Depends on bdq_pkg.
interface bdq_op_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface bdq_res_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STAT_W-1:0]        status;

  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface

/* hw/rtl/bounded_deque_top.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words over a circular RAM.
// Depends on bdq_pkg, bdq_ifs and bdq_ram.
//
// Each operation transaction (push front, pop front, push back, pop back)
// returns exactly one result transaction with the popped word and a status.
// Pushes, overflowing pushes and underflowing pops load the result register
// on acceptance; a pop that removes a word passes through S_READ to wait for
// the registered read port of the entry RAM. The result register frees the
// input side as soon as the result is taken, so a new operation enters in the
// cycle its predecessor's result leaves. The capacity register (reset 16,
// clamped to the store depth) is written through the cfg channel, always
// ready, and applies from the next operation. No clearing pass runs after reset.
module bounded_deque_top import bdq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bdq_op_if.sink           in_op,
  bdq_res_if.source        out_res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0]    capacity_r;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                in_acc;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    limit;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data;

  assign cfg_ready = 1'b1;

  assign in_op.ready   = (state_r == S_IDLE) && (!out_valid_r || out_res.ready);
  assign in_acc        = in_op.valid && in_op.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;
  assign out_res.status = out_status_r;

  assign limit = (CMP_W'(capacity_r) < CMP_W'(DEPTH)) ? CMP_W'(capacity_r) : CMP_W'(DEPTH);
  assign full  = CMP_W'(count_r) >= limit;
  assign empty = (count_r == '0);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
          out_valid_nxt  = 1'b1;
          case (kind_t'(in_op.kind))
            K_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                head_nxt  = wr_addr;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            K_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap_add(head_r, count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            K_POP_FRONT: begin
              if (empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = head_r;
                head_nxt      = wrap_add(head_r, CNT_W'(1));
                count_nxt     = count_r - CNT_W'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            K_POP_BACK: begin
              if (empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = wrap_add(head_r, count_r - CNT_W'(1));
                count_nxt     = count_r - CNT_W'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        out_data_nxt  = rd_data;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_op.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* hw/rtl/bdq_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/bdq_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for bounded_deque_top, attached by bind.
// Depends on bdq_pkg and bounded_deque_top.
module bdq_chk import bdq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_data,
  input logic [STAT_W-1:0] out_status
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data) && $stable(out_status))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_data == '0)
    else $error("failed operation returned nonzero data");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 1) || $past(in_acc, 2))
    else $error("result without a recent operation");

endmodule

bind bounded_deque_top bdq_chk u_bdq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_op.valid),
  .in_ready   (in_op.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_data   (out_res.data),
  .out_status (out_res.status)
);

/* verif/bounded_deque_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_top: drives random deque operations
// and capacity settings and checks each result against a cycle-free mirror of the deque.
// Depends on bdq_pkg, bdq_ifs and the bounded_deque_top RTL.
module bounded_deque_top_tb;
  import bdq_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
  } deque_result_t;

  class deque_mirror;
    logic [DATA_W-1:0] words[DEPTH];
    int unsigned       head = 0;
    int unsigned       count = 0;
    int unsigned       capacity = 16;
    int unsigned       errors = 0;
    deque_result_t     pending_results[$];

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = 32'(c);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void apply_op(kind_t k, logic [DATA_W-1:0] v);
      deque_result_t r;
      int unsigned   lim;
      r.data = '0;
      r.status = ST_OK;
      lim = (capacity > DEPTH) ? DEPTH : capacity;
      case (k)
        K_PUSH_FRONT, K_PUSH_BACK: begin
          if (count >= lim) begin
            r.status = ST_OVERFLOW;
          end else if (k == K_PUSH_FRONT) begin
            head = (head == 0) ? DEPTH - 1 : head - 1;
            words[head] = v;
            count++;
          end else begin
            words[(head + count) % DEPTH] = v;
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            r.status = ST_UNDERFLOW;
          end else if (k == K_POP_FRONT) begin
            r.data = words[head];
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            r.data = words[(head + count - 1) % DEPTH];
            count--;
          end
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] d, logic [STAT_W-1:0] s);
      deque_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: data %0d status %0d", $signed(d), s);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (d !== e.data) begin
        $error("data mismatch: expected %0d, actual %0d", $signed(e.data), $signed(d));
        errors++;
      end
      if (s !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, s);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;
  logic             tx_steady;

  bdq_op_if  op_ch ();
  bdq_res_if res_ch ();

  deque_mirror mirror = new();

  bounded_deque_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (op_ch),
    .out_res   (res_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(input kind_t k, input logic [DATA_W-1:0] v);
    int g;
    g = tx_steady ? 0 : pick_gap();
    if (g > 0) begin
      op_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.kind  <= k;
    op_ch.value <= v;
    do @(posedge clk); while (!op_ch.ready);
    mirror.apply_op(k, v);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    op_ch.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.set_capacity(c);
  endtask

  // hold result ready high in stretches, otherwise stall at random
  initial begin
    int g;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          res_ch.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      mirror.check_result(res_ch.data, res_ch.status);
    end
  end

  initial begin
    #5_000_000;
    $display("bounded_deque_top regression: fail");
    $finish;
  end

  initial begin
    int          sent;
    int          phase_len;
    int          push_pct;
    int          phase;
    logic        is_push;
    logic        at_front;
    kind_t       k;
    logic [CAP_W-1:0] cap;

    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    op_ch.valid <= 1'b0;
    op_ch.kind  <= K_PUSH_FRONT;
    op_ch.value <= '0;
    tx_steady   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pops on empty, extreme words at both ends, then drain
    send_op(K_POP_FRONT, 32'h7fff_ffff);
    send_op(K_POP_BACK, 32'h8000_0000);
    send_op(K_PUSH_FRONT, 32'h8000_0000);
    send_op(K_PUSH_BACK, 32'h7fff_ffff);
    send_op(K_PUSH_FRONT, 32'h0000_0000);
    send_op(K_PUSH_BACK, 32'hffff_ffff);
    send_op(K_POP_BACK, 32'h1234_5678);
    send_op(K_POP_FRONT, '1);
    send_op(K_POP_FRONT, '0);
    send_op(K_POP_BACK, 32'h5555_aaaa);

    // zero capacity: every push overflows, every pop underflows
    write_capacity('0);
    send_op(K_PUSH_FRONT, 32'h0000_0001);
    send_op(K_PUSH_BACK, 32'hdead_beef);
    send_op(K_POP_FRONT, '0);
    send_op(K_POP_BACK, '0);

    // fill a small deque, then lower the limit below the count
    write_capacity(5'd3);
    send_op(K_PUSH_BACK, 32'h0000_0011);
    send_op(K_PUSH_FRONT, 32'h0000_0022);
    send_op(K_PUSH_BACK, 32'h0000_0033);
    send_op(K_PUSH_FRONT, 32'h0000_0044);
    write_capacity(5'd1);
    send_op(K_PUSH_BACK, 32'h0000_0055);
    send_op(K_POP_FRONT, '0);
    send_op(K_POP_BACK, '0);
    send_op(K_PUSH_FRONT, 32'h0000_0066);
    send_op(K_POP_BACK, '0);
    send_op(K_PUSH_FRONT, 32'h0000_0077);

    sent = 0;
    phase = 0;
    while (sent < 850) begin
      case (phase)
        0: cap = 5'd31;
        1: cap = 5'd16;
        2: cap = 5'd0;
        3: cap = 5'd1;
        4: cap = 5'd17;
        5: cap = 5'd8;
        default: cap = CAP_W'($urandom_range(0, 31));
      endcase
      write_capacity(cap);
      push_pct = (phase == 0) ? 80 : 20 + 30 * int'($urandom_range(0, 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 110);
      for (int i = 0; i < phase_len; i++) begin
        if ((i % 40) == 39) push_pct = 100 - push_pct;
        is_push  = ($urandom_range(0, 99) < push_pct);
        at_front = 1'($urandom_range(0, 1));
        if (is_push) k = at_front ? K_PUSH_FRONT : K_PUSH_BACK;
        else k = at_front ? K_POP_FRONT : K_POP_BACK;
        send_op(k, pick_word());
      end
      sent += phase_len;
      phase++;
    end
    op_ch.valid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("bounded_deque_top regression: pass");
    end else begin
      $display("bounded_deque_top regression: fail");
    end
    $finish;
  end

endmodule
